// ----- sv/pbd_pkg.sv -----
package pbd_pkg;

	// result kinds on the output channel
	typedef enum logic [2:0] {
		KIND_SCALAR  = 3'd0,
		KIND_HEADER  = 3'd1,
		KIND_PAYLOAD = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_ERROR   = 3'd4
	} result_kind_t;

	// one decoded result
	typedef struct packed {
		result_kind_t kind;
		logic [31:0]  field_id;
		logic [2:0]   wire_code;
		logic [63:0]  field_value;
		logic [7:0]   payload_byte;
		logic         last_payload;
		logic         last_of_run;
	} result_t;

	// what one input byte produces: up to two results
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} burst_t;

	// result queue depth and pointer width
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = $clog2(QDEPTH);
	localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

	// longest varint in bytes, minus one
	localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

	// wire types the decoder accepts, from the low three key bits
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LENGTH  = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

endpackage

// ----- sv/pbd_if.sv -----
interface pbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface pbd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [31:0] field_id;
	logic [2:0]  wire_code;
	logic [63:0] field_value;
	logic [7:0]  payload_byte;
	logic        last_payload;
	logic        last_of_run;

	modport source (output valid, output result_kind, output field_id, output wire_code,
		output field_value, output payload_byte, output last_payload, output last_of_run,
		input ready);
	modport sink (input valid, input result_kind, input field_id, input wire_code,
		input field_value, input payload_byte, input last_payload, input last_of_run,
		output ready);
endinterface

// ----- sv/pbd_core.sv -----
module pbd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     data_byte,
	input  logic           end_of_message,
	output pbd_pkg::burst_t burst
);

	typedef enum logic [2:0] {
		PH_KEY     = 3'd0,
		PH_VARINT  = 3'd1,
		PH_FIXED   = 3'd2,
		PH_LENGTH  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_SKIP    = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  vidx_q, vidx_d;
	logic [31:0] held_fn_q, held_fn_d;
	logic [2:0]  held_wt_q, held_wt_d;
	logic [2:0]  fcnt_q, fcnt_d;
	logic [63:0] rem_q, rem_d;

	logic [6:0]  vshift;
	logic [63:0] vacc;
	logic        vdone;
	logic        vover;
	logic [63:0] facc;
	logic [3:0]  fcnt_inc;
	logic [3:0]  fneed;
	logic [63:0] rem_dec;
	logic        err;
	logic        clear;
	logic [1:0]  n;
	pbd_pkg::result_t fres;
	pbd_pkg::result_t tail;

	function automatic pbd_pkg::result_t mk_result(pbd_pkg::result_kind_t kind,
		logic [31:0] fn, logic [2:0] wt, logic [63:0] val, logic [7:0] pb, logic lastp);
		pbd_pkg::result_t r;
		r.kind         = kind;
		r.field_id     = fn;
		r.wire_code    = wt;
		r.field_value  = val;
		r.payload_byte = pb;
		r.last_payload = lastp;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	// varint byte merge, shared by key, varint and length phases
	assign vshift = 7'(vidx_q) * 7'd7;
	assign vacc   = acc_q | (64'(data_byte[6:0]) << vshift);
	assign vdone  = !data_byte[7] && (vidx_q <= pbd_pkg::VARINT_LAST_IDX);
	assign vover  = (vidx_q > pbd_pkg::VARINT_LAST_IDX) ||
		(data_byte[7] && (vidx_q == pbd_pkg::VARINT_LAST_IDX));

	// little-endian fixed field merge
	assign facc     = acc_q | (64'(data_byte) << {fcnt_q, 3'b000});
	assign fcnt_inc = 4'(fcnt_q) + 4'd1;
	assign fneed    = (held_wt_q == pbd_pkg::WIRE_FIXED64) ? 4'd8 : 4'd4;
	assign rem_dec  = rem_q - 64'd1;

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		vidx_d    = vidx_q;
		held_fn_d = held_fn_q;
		held_wt_d = held_wt_q;
		fcnt_d    = fcnt_q;
		rem_d     = rem_q;
		err       = 1'b0;
		clear     = 1'b0;
		n         = 2'd0;
		fres      = mk_result(pbd_pkg::KIND_SCALAR, 32'd0, 3'd0, 64'd0, 8'd0, 1'b0);
		tail      = mk_result(pbd_pkg::KIND_DONE, 32'd0, 3'd0, 64'd0, 8'd0, 1'b0);
		burst     = '0;

		if (phase_q == PH_SKIP) begin
			clear = end_of_message;
		end else begin
			case (phase_q)
				PH_VARINT: begin
					if (vover) begin
						err   = 1'b1;
						acc_d = vacc;
					end else if (vdone) begin
						fres = mk_result(pbd_pkg::KIND_SCALAR, held_fn_q, held_wt_q, vacc,
							8'd0, 1'b0);
						n       = 2'd1;
						phase_d = PH_KEY;
						acc_d   = 64'd0;
						vidx_d  = 4'd0;
						fcnt_d  = 3'd0;
						rem_d   = 64'd0;
					end else begin
						acc_d  = vacc;
						vidx_d = vidx_q + 4'd1;
					end
				end
				PH_FIXED: begin
					if (fcnt_inc >= fneed) begin
						fres = mk_result(pbd_pkg::KIND_SCALAR, held_fn_q, held_wt_q, facc,
							8'd0, 1'b0);
						n       = 2'd1;
						phase_d = PH_KEY;
						acc_d   = 64'd0;
						vidx_d  = 4'd0;
						fcnt_d  = 3'd0;
						rem_d   = 64'd0;
					end else begin
						acc_d  = facc;
						fcnt_d = fcnt_inc[2:0];
					end
				end
				PH_LENGTH: begin
					if (vover) begin
						err   = 1'b1;
						acc_d = vacc;
					end else if (vdone) begin
						fres = mk_result(pbd_pkg::KIND_HEADER, held_fn_q, held_wt_q, vacc,
							8'd0, 1'b0);
						n      = 2'd1;
						vidx_d = 4'd0;
						acc_d  = 64'd0;
						if (vacc == 64'd0) begin
							phase_d = PH_KEY;
							fcnt_d  = 3'd0;
							rem_d   = 64'd0;
						end else begin
							phase_d = PH_PAYLOAD;
							rem_d   = vacc;
						end
					end else begin
						acc_d  = vacc;
						vidx_d = vidx_q + 4'd1;
					end
				end
				PH_PAYLOAD: begin
					fres = mk_result(pbd_pkg::KIND_PAYLOAD, held_fn_q, held_wt_q, 64'd0,
						data_byte, rem_dec == 64'd0);
					n = 2'd1;
					if (rem_dec == 64'd0) begin
						phase_d = PH_KEY;
						acc_d   = 64'd0;
						vidx_d  = 4'd0;
						fcnt_d  = 3'd0;
						rem_d   = 64'd0;
					end else begin
						rem_d = rem_dec;
					end
				end
				default: begin
					// key varint
					if (vover) begin
						err   = 1'b1;
						acc_d = vacc;
					end else if (vdone) begin
						acc_d  = 64'd0;
						fcnt_d = 3'd0;
						vidx_d = 4'd0;
						if (vacc[63:3] == 61'd0) begin
							err = 1'b1;
						end else begin
							held_fn_d = vacc[34:3];
							held_wt_d = vacc[2:0];
							case (vacc[2:0])
								pbd_pkg::WIRE_VARINT:  phase_d = PH_VARINT;
								pbd_pkg::WIRE_FIXED64: phase_d = PH_FIXED;
								pbd_pkg::WIRE_FIXED32: phase_d = PH_FIXED;
								pbd_pkg::WIRE_LENGTH:  phase_d = PH_LENGTH;
								default:               err = 1'b1;
							endcase
						end
					end else begin
						acc_d  = vacc;
						vidx_d = vidx_q + 4'd1;
					end
				end
			endcase

			// trailing error or done result
			if (err) begin
				tail = mk_result(pbd_pkg::KIND_ERROR, 32'd0, 3'd0, 64'd0, 8'd0, 1'b0);
				if (end_of_message) begin
					clear = 1'b1;
				end else begin
					phase_d = PH_SKIP;
				end
			end else if (end_of_message) begin
				if (phase_d == PH_KEY && vidx_d == 4'd0) begin
					tail = mk_result(pbd_pkg::KIND_DONE, 32'd0, 3'd0, 64'd0, 8'd0, 1'b0);
				end else begin
					tail = mk_result(pbd_pkg::KIND_ERROR, 32'd0, 3'd0, 64'd0, 8'd0, 1'b0);
				end
				clear = 1'b1;
			end

			if (err || end_of_message) begin
				tail.last_of_run = 1'b1;
				if (n == 2'd0) begin
					burst.count = 2'd1;
					burst.first = tail;
				end else begin
					burst.count = 2'd2;
					burst.first = fres;
					burst.second = tail;
				end
			end else if (n != 2'd0) begin
				fres.last_of_run = 1'b1;
				burst.count = 2'd1;
				burst.first = fres;
			end
		end

		if (clear) begin
			phase_d   = PH_KEY;
			acc_d     = 64'd0;
			vidx_d    = 4'd0;
			held_fn_d = 32'd0;
			held_wt_d = 3'd0;
			fcnt_d    = 3'd0;
			rem_d     = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_KEY;
			acc_q     <= 64'd0;
			vidx_q    <= 4'd0;
			held_fn_q <= 32'd0;
			held_wt_q <= 3'd0;
			fcnt_q    <= 3'd0;
			rem_q     <= 64'd0;
		end else if (take) begin
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			vidx_q    <= vidx_d;
			held_fn_q <= held_fn_d;
			held_wt_q <= held_wt_d;
			fcnt_q    <= fcnt_d;
			rem_q     <= rem_d;
		end
	end

	// skipping bytes produce nothing
	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_SKIP) |-> burst.count == 2'd0)
		else $error("result produced while skipping");

	// payload phase always holds a nonzero remaining count
	a_payload_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> rem_q != 64'd0)
		else $error("payload phase with zero remaining");

	// varint byte index never passes the last legal byte
	a_vidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vidx_q <= pbd_pkg::VARINT_LAST_IDX)
		else $error("varint index out of range");

endmodule

// ----- sv/pbd_resq.sv -----
module pbd_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pbd_pkg::burst_t  burst,
	input  logic             pop,
	output logic             room,
	output logic             nonempty,
	output pbd_pkg::result_t head
);

	localparam logic [pbd_pkg::QCOUNT_W-1:0] DEPTH_C = pbd_pkg::QCOUNT_W'(pbd_pkg::QDEPTH);

	pbd_pkg::result_t               entry_q [pbd_pkg::QDEPTH];
	logic [pbd_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [pbd_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [pbd_pkg::QCOUNT_W-1:0]   cnt_q;
	logic [pbd_pkg::QCOUNT_W-1:0]   push_n;
	logic                           pop_ok;

	assign push_n   = push ? pbd_pkg::QCOUNT_W'(burst.count) : '0;
	assign pop_ok   = pop && nonempty;
	assign nonempty = cnt_q != '0;
	// room for a full two-result burst
	assign room     = cnt_q <= DEPTH_C - pbd_pkg::QCOUNT_W'(2);
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && burst.count != 2'd0) begin
			entry_q[wr_ptr_q] <= burst.first;
		end
		if (push && burst.count == 2'd2) begin
			entry_q[wr_ptr_q + pbd_pkg::QPTR_W'(1)] <= burst.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + pbd_pkg::QPTR_W'(push_n);
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + pbd_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + push_n - (pop_ok ? pbd_pkg::QCOUNT_W'(1) : '0);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("push without room");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ok && push_n == '0) |=> cnt_q == $past(cnt_q) - pbd_pkg::QCOUNT_W'(1))
		else $error("queue count did not drop on pop");

endmodule

// ----- sv/protobuf_message_decoder.sv -----
// protobuf wire-format decoder. Takes a serialized message one byte per
// transaction on msg, end_of_message set on its last byte, and gives decoded
// results one per transaction on res: a scalar for each varint, fixed64 or
// fixed32 field, a header carrying the length of each length-delimited field
// followed by one result per payload byte, then a done result at the end of
// the message. Zero field numbers, wire types 3, 4, 6 and 7, varints longer
// than ten bytes and a message that stops inside a field give an error
// result; bytes after an error are dropped up to and including the end of
// that message, and results already given are not withdrawn. last_of_run
// marks the final result caused by one input byte. Rate: one byte per clock
// cycle while the queue has room; its results queue behind earlier ones. Each
// byte is decoded combinationally between the parser state registers and a
// four-entry result queue; a byte that ends a field and the message at once
// gives two results, and msg.ready drops only while the queue holds more than
// two results, so back-pressure on res stalls the input once three or more
// results are buffered. No clearing pass is needed after reset.
module protobuf_message_decoder (
	input  logic      clk,
	input  logic      arst_n,
	pbd_in_if.sink    msg,
	pbd_out_if.source res
);

	logic             take;
	logic             room;
	logic             nonempty;
	pbd_pkg::burst_t  burst;
	pbd_pkg::result_t head;

	// a byte is taken only when the queue can absorb two results
	assign msg.ready = room;
	assign take      = msg.valid && room;

	// parser: state registers plus combinational decode of one byte
	pbd_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (msg.data_byte),
		.end_of_message (msg.end_of_message),
		.burst          (burst)
	);

	// result queue, registered head drives the output channel
	pbd_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.burst    (burst),
		.pop      (res.ready),
		.room     (room),
		.nonempty (nonempty),
		.head     (head)
	);

	assign res.valid        = nonempty;
	assign res.result_kind  = head.kind;
	assign res.field_id     = head.field_id;
	assign res.wire_code    = head.wire_code;
	assign res.field_value  = head.field_value;
	assign res.payload_byte = head.payload_byte;
	assign res.last_payload = head.last_payload;
	assign res.last_of_run  = head.last_of_run;

	// every done or error result closes its run
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (head.kind == pbd_pkg::KIND_DONE || head.kind == pbd_pkg::KIND_ERROR))
		|-> head.last_of_run)
		else $error("done or error result not last of run");

	// with no byte taken and the queue empty, no result appears on the next edge
	a_idle_input: assert property (@(posedge clk) disable iff (!arst_n)
		(!take && !res.valid) |=> !res.valid)
		else $error("result appeared without input");

	// a payload result never carries a field value
	a_payload_value: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && head.kind == pbd_pkg::KIND_PAYLOAD) |-> head.field_value == 64'd0)
		else $error("payload result with nonzero value");

endmodule
